// File: src/tgal_pkg.sv
// Shared types and constants for the text glyph address and layout block.
package tgal_pkg;

	// Input action codes
	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_TEXT  = 1'b1;

	// Configuration register indexes
	localparam logic [7:0] REG_GLYPH_SIZE    = 8'd0;
	localparam logic [7:0] REG_LINE_WIDTH    = 8'd1;
	localparam logic [7:0] REG_WIDE16_BASE   = 8'd2;
	localparam logic [7:0] REG_WIDE24_BASE   = 8'd3;
	localparam logic [7:0] REG_WIDE32_BASE   = 8'd4;
	localparam logic [7:0] REG_NARROW16_BASE = 8'd5;
	localparam logic [7:0] REG_NARROW24_BASE = 8'd6;
	localparam logic [7:0] REG_NARROW32_BASE = 8'd7;

	// Register values after reset
	localparam logic [5:0]  RST_GLYPH_SIZE    = 6'd16;
	localparam logic [7:0]  RST_LINE_WIDTH    = 8'd240;
	localparam logic [23:0] RST_WIDE16_BASE   = 24'd0;
	localparam logic [23:0] RST_WIDE24_BASE   = 24'd261702;
	localparam logic [23:0] RST_WIDE32_BASE   = 24'd850524;
	localparam logic [23:0] RST_NARROW16_BASE = 24'd1897314;
	localparam logic [23:0] RST_NARROW24_BASE = 24'd1899368;
	localparam logic [23:0] RST_NARROW32_BASE = 24'd1905518;

	typedef struct packed {
		logic [5:0]  glyph_size;
		logic [7:0]  line_width;
		logic [23:0] wide16_base;
		logic [23:0] wide24_base;
		logic [23:0] wide32_base;
		logic [23:0] narrow16_base;
		logic [23:0] narrow24_base;
		logic [23:0] narrow32_base;
	} cfg_t;

	// One classified glyph waiting for its address computation
	typedef struct packed {
		logic signed [16:0] operand;   // glyph index (may be negative on bad codes)
		logic [9:0]         bytes;     // full bitmap byte count
		logic [23:0]        base;      // selected font base
		logic [7:0]         x;
		logic [7:0]         y;
		logic               is_wide;
		logic               bad;
	} job_t;

	// Front to queue write side
	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

endpackage

// File: src/tgal_front.sv
// Front end: accepts text items, tracks cursor and lead byte, classifies glyphs.
module tgal_front import tgal_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] code_byte,
	input  logic [7:0] start_x,
	input  logic [7:0] start_y,
	input  logic       q_full,
	output push_t      wr
);

	localparam logic [5:0] SIZE16 = 6'd16;
	localparam logic [5:0] SIZE24 = 6'd24;
	localparam logic [5:0] SIZE32 = 6'd32;
	localparam logic [7:0] LEAD_MIN = 8'hA0;

	logic [7:0] cursor_col_q;
	logic [7:0] cursor_row_q;
	logic [7:0] lead_code_q;
	logic       lead_pending_q;

	logic              fire;
	logic [5:0]        size;
	logic [4:0]        half;
	logic [2:0]        ceil_n;
	logic [3:0]        ceil_w;
	logic [9:0]        nbytes;
	logic [9:0]        wbytes;
	logic              is_text;
	logic              is_end;
	logic              wide_hit;
	logic              narrow_hit;
	logic              lead_hit;
	logic [5:0]        adv;
	logic [7:0]        nx;
	logic signed [9:0] lim;
	logic              wrap;
	logic signed [16:0] lead_off;
	logic signed [16:0] trail_off;
	logic signed [16:0] wide_idx;
	logic [23:0]       wide_base;
	logic [23:0]       narrow_base;

	assign fire     = in_valid & ~q_full;
	assign in_stall = q_full;

	// Byte counts per glyph
	assign size   = cfg.glyph_size;
	assign half   = size[5:1];
	assign ceil_n = 3'((6'(half) + 6'd7) >> 3);
	assign ceil_w = 4'((7'(size) + 7'd7) >> 3);
	assign nbytes = 10'(size) * 10'(ceil_n);
	assign wbytes = 10'(size) * 10'(ceil_w);

	// Classify the byte
	assign is_text    = (action == ACT_TEXT);
	assign is_end     = (code_byte == 8'd0);
	assign wide_hit   = is_text & ~is_end & lead_pending_q;
	assign narrow_hit = is_text & ~is_end & ~lead_pending_q & (code_byte < LEAD_MIN);
	assign lead_hit   = is_text & ~is_end & ~lead_pending_q & (code_byte >= LEAD_MIN);

	// Cursor advance and line wrap
	assign adv  = wide_hit ? size : {1'b0, half};
	assign nx   = cursor_col_q + 8'(adv);
	assign lim  = $signed({2'b00, cfg.line_width}) - $signed({4'b0000, adv});
	assign wrap = $signed({2'b00, nx}) > lim;

	// Two-byte glyph index
	assign lead_off  = $signed({9'd0, lead_code_q}) - 17'sd161;
	assign trail_off = $signed({9'd0, code_byte}) - 17'sd161;
	assign wide_idx  = lead_off * 17'sd94 + trail_off;

	// Font base by size
	always_comb begin
		unique case (size)
			SIZE16: begin
				wide_base   = cfg.wide16_base;
				narrow_base = cfg.narrow16_base;
			end
			SIZE24: begin
				wide_base   = cfg.wide24_base;
				narrow_base = cfg.narrow24_base;
			end
			SIZE32: begin
				wide_base   = cfg.wide32_base;
				narrow_base = cfg.narrow32_base;
			end
			default: begin
				wide_base   = 24'd0;
				narrow_base = 24'd0;
			end
		endcase
	end

	// Build the job for the queue
	always_comb begin
		wr.push        = fire & (wide_hit | narrow_hit);
		wr.job.x       = cursor_col_q;
		wr.job.y       = cursor_row_q;
		wr.job.is_wide = wide_hit;
		wr.job.bad     = wide_hit & ((lead_code_q < 8'hA1) | (code_byte < 8'hA1));
		if (wide_hit) begin
			wr.job.operand = wide_idx;
			wr.job.bytes   = wbytes;
			wr.job.base    = wide_base;
		end else begin
			wr.job.operand = $signed({9'd0, code_byte});
			wr.job.bytes   = nbytes;
			wr.job.base    = narrow_base;
		end
	end

	// Update cursor and lead state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q   <= 8'd0;
			cursor_row_q   <= 8'd0;
			lead_code_q    <= 8'd0;
			lead_pending_q <= 1'b0;
		end else if (fire) begin
			if (!is_text) begin
				cursor_col_q   <= start_x;
				cursor_row_q   <= start_y;
				lead_pending_q <= 1'b0;
			end else if (is_end) begin
				lead_pending_q <= 1'b0;
			end else if (lead_hit) begin
				lead_code_q    <= code_byte;
				lead_pending_q <= 1'b1;
			end else begin
				lead_pending_q <= 1'b0;
				if (wrap) begin
					cursor_col_q <= 8'd0;
					cursor_row_q <= cursor_row_q + 8'(size);
				end else begin
					cursor_col_q <= nx;
				end
			end
		end
	end

	a_place_drops_lead: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action == ACT_PLACE |=> !lead_pending_q)
		else $error("lead byte kept across a place action");

endmodule

// File: src/tgal_fifo.sv
// Two-entry job queue between the front end and the address back end.
module tgal_fifo import tgal_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t wr,
	output logic  full,
	output logic  rd_valid,
	output job_t  rd_job,
	input  logic  pop
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !rd_valid))
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

// File: src/tgal_back.sv
// Back end: multiplies glyph index by byte count, adds the font base, holds the result.
module tgal_back import tgal_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  job_t        q_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] glyph_addr,
	output logic [7:0]  glyph_bytes,
	output logic [7:0]  glyph_x,
	output logic [7:0]  glyph_y,
	output logic        is_wide,
	output logic        bad_code
);

	logic               valid_s1;
	logic signed [27:0] prod_s1;
	logic [9:0]         bytes_s1;
	logic [23:0]        base_s1;
	logic [7:0]         x_s1;
	logic [7:0]         y_s1;
	logic               wide_s1;
	logic               bad_s1;

	logic               valid_s2;
	logic [23:0]        addr_s2;
	logic [7:0]         bytes_s2;
	logic [7:0]         x_s2;
	logic [7:0]         y_s2;
	logic               wide_s2;
	logic               bad_s2;

	logic                 out_free;
	logic                 s1_free;
	logic [ADDR_BITS-1:0] offset;
	logic [ADDR_BITS-1:0] addr_sum;

	assign out_free = ~valid_s2 | ~out_stall;
	assign s1_free  = ~valid_s1 | out_free;
	assign pop      = q_valid & s1_free;

	// Wrap offset and base to the address width
	assign offset   = ADDR_BITS'(prod_s1);
	assign addr_sum = offset + ADDR_BITS'(base_s1);

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= 28'(q_job.operand) * 28'($signed({1'b0, q_job.bytes}));
			bytes_s1 <= q_job.bytes;
			base_s1  <= q_job.base;
			x_s1     <= q_job.x;
			y_s1     <= q_job.y;
			wide_s1  <= q_job.is_wide;
			bad_s1   <= q_job.bad;
		end
	end

	// Output register: add base, saturate byte count, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			addr_s2  <= 24'(addr_sum);
			bytes_s2 <= (bytes_s1 > 10'd255) ? 8'd255 : bytes_s1[7:0];
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			wide_s2  <= wide_s1;
			bad_s2   <= bad_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign glyph_addr  = addr_s2;
	assign glyph_bytes = bytes_s2;
	assign glyph_x     = x_s2;
	assign glyph_y     = y_s2;
	assign is_wide     = wide_s2;
	assign bad_code    = bad_s2;

endmodule

// File: src/text_glyph_address_layout.sv
// Top level of the text glyph address and layout block with its register file.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall   | action, code_byte, start_x, start_y
//  out     | output    | out_valid / out_stall | glyph_addr, glyph_bytes, glyph_x,
//          |           |                       | glyph_y, is_wide, bad_code
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A text byte is classified and the cursor updated in the cycle of its transfer; one item
// per cycle is taken while the two-entry job queue has room.
// A glyph result passes through the job queue, the index by byte-count multiply register
// and the base add into the output register. Output stalls back up through the queue; the
// input stalls only once the queue is full. Reset (arst_n low) clears the cursor, the
// pending lead byte and the queue, and loads the registers with their reset values.
module text_glyph_address_layout import tgal_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  code_byte,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] glyph_addr,
	output logic [7:0]  glyph_bytes,
	output logic [7:0]  glyph_x,
	output logic [7:0]  glyph_y,
	output logic        is_wide,
	output logic        bad_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t  cfg_q;
	push_t wr;
	logic  q_full;
	logic  q_valid;
	job_t  q_job;
	logic  pop;

	assign cfg_ready = 1'b1;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_size    <= RST_GLYPH_SIZE;
			cfg_q.line_width    <= RST_LINE_WIDTH;
			cfg_q.wide16_base   <= RST_WIDE16_BASE;
			cfg_q.wide24_base   <= RST_WIDE24_BASE;
			cfg_q.wide32_base   <= RST_WIDE32_BASE;
			cfg_q.narrow16_base <= RST_NARROW16_BASE;
			cfg_q.narrow24_base <= RST_NARROW24_BASE;
			cfg_q.narrow32_base <= RST_NARROW32_BASE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GLYPH_SIZE:    cfg_q.glyph_size    <= cfg_data[5:0];
				REG_LINE_WIDTH:    cfg_q.line_width    <= cfg_data[7:0];
				REG_WIDE16_BASE:   cfg_q.wide16_base   <= cfg_data[23:0];
				REG_WIDE24_BASE:   cfg_q.wide24_base   <= cfg_data[23:0];
				REG_WIDE32_BASE:   cfg_q.wide32_base   <= cfg_data[23:0];
				REG_NARROW16_BASE: cfg_q.narrow16_base <= cfg_data[23:0];
				REG_NARROW24_BASE: cfg_q.narrow24_base <= cfg_data[23:0];
				REG_NARROW32_BASE: cfg_q.narrow32_base <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	tgal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.code_byte (code_byte),
		.start_x   (start_x),
		.start_y   (start_y),
		.q_full    (q_full),
		.wr        (wr)
	);

	tgal_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.pop      (pop)
	);

	tgal_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (q_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.glyph_addr  (glyph_addr),
		.glyph_bytes (glyph_bytes),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.is_wide     (is_wide),
		.bad_code    (bad_code)
	);

endmodule
